// File: hdl/pres_pkg.sv
`timescale 1ns / 1ps

package pres_pkg;

  localparam int FIELD_W = 16;

  // opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_APPEND = 1'b1;

  // result status codes
  localparam logic [1:0] ST_TICK_OK = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] target_level;
    logic [FIELD_W-1:0] step_size;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pwm_level;
    logic               event_done;
    logic [1:0]         status;
  } out_item_t;

endpackage

// File: hdl/pwm_ramp_event_sequencer_core.sv
`timescale 1ns / 1ps

// Ramp event sequencer: appends ramp events to a table RAM and replays them tick by tick.
// Result: an append or refused tick is registered out in the cycle after the transfer; a tick
//   is read into rd_data_r, stepped in S_TICK, then registered. One item per cycle for an
//   append or refused tick; busy covers a tick's step compute after the synchronous RAM read.
// Reset (rst_n, synchronous): empty table, level 0, first event index; RAM is not cleared.
// The receiver cannot stall: out_valid marks the single cycle a result is presented.
module pwm_ramp_event_sequencer_core
  import pres_pkg::*;
#(
  parameter int EVENT_DEPTH = 16,
  parameter int LEVEL_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IDX_W = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
  localparam int CNT_W = $clog2(EVENT_DEPTH + 1);
  localparam int ENT_W = 3 * LEVEL_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TICK = 2'b10
  } state_t;

  // control
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;       // stored events
  logic [IDX_W-1:0]       cur_r, cur_nxt;           // event being replayed
  logic [IDX_W-1:0]       tick_idx_r, tick_idx_nxt; // index read for the pending tick
  logic [LEVEL_WIDTH-1:0] replay_r, replay_nxt;     // last level driven
  logic                   fresh_r, fresh_nxt;       // next tick restarts at event start
  logic [LEVEL_WIDTH-1:0] builder_r, builder_nxt;   // end level of last appended event
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  // event table: {start, target, step}
  logic [ENT_W-1:0] event_mem [EVENT_DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  logic                   accept;
  logic                   is_append;
  logic                   full;
  logic                   empty;
  logic                   wr_en;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_idx;
  logic [ENT_W-1:0]       wr_data;
  logic [LEVEL_WIDTH-1:0] in_target;
  logic [LEVEL_WIDTH-1:0] in_step;

  logic [LEVEL_WIDTH-1:0] ev_start;
  logic [LEVEL_WIDTH-1:0] ev_target;
  logic [LEVEL_WIDTH-1:0] ev_step;
  logic [LEVEL_WIDTH-1:0] lvl_from;
  logic [LEVEL_WIDTH-1:0] lvl_next;
  logic                   done;
  logic [CNT_W-1:0]       idx_inc;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && (state_r == S_IDLE);
  assign is_append = (in_data.opcode == OP_APPEND);
  assign full      = (count_r == CNT_W'(EVENT_DEPTH));
  assign empty     = (count_r == '0);
  assign in_target = in_data.target_level[LEVEL_WIDTH-1:0];
  assign in_step   = in_data.step_size[LEVEL_WIDTH-1:0];
  assign wr_en     = accept && is_append && !full;
  assign rd_en     = accept && !is_append && !empty;
  assign wr_data   = {builder_r, in_target, in_step};

  // index may be stale past count after appends; wrap to first event
  assign rd_idx = (CNT_W'(cur_r) >= count_r) ? '0 : cur_r;

  // RAM: one write port, one registered read port. Reads and writes only happen
  // on transfer edges, so they never collide.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      event_mem[count_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= event_mem[rd_idx];
    end
  end

  assign ev_start  = rd_data_r[ENT_W-1 -: LEVEL_WIDTH];
  assign ev_target = rd_data_r[2*LEVEL_WIDTH-1 -: LEVEL_WIDTH];
  assign ev_step   = rd_data_r[LEVEL_WIDTH-1:0];
  assign lvl_from  = fresh_r ? ev_start : replay_r;

  pres_level_step #(
    .LEVEL_WIDTH(LEVEL_WIDTH)
  ) u_step (
    .level      (lvl_from),
    .target     (ev_target),
    .step       (ev_step),
    .level_next (lvl_next)
  );

  assign done    = (lvl_next == ev_target);
  assign idx_inc = CNT_W'(tick_idx_r) + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    tick_idx_nxt  = tick_idx_r;
    replay_nxt    = replay_r;
    fresh_nxt     = fresh_r;
    builder_nxt   = builder_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_data_nxt.pwm_level  = '0;
          out_data_nxt.event_done = 1'b0;
          if (is_append) begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_data_nxt.status = ST_FULL;
            end else begin
              out_data_nxt.status = ST_ADDED;
              count_nxt           = count_r + CNT_W'(1);
              builder_nxt         = in_target;
            end
          end else if (empty) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_EMPTY;
          end else begin
            tick_idx_nxt = rd_idx;
            state_nxt    = S_TICK;
          end
        end
      end

      S_TICK: begin
        // table entry is in rd_data_r now; step and present the level
        out_valid_nxt           = 1'b1;
        out_data_nxt.pwm_level  = FIELD_W'(lvl_next);
        out_data_nxt.event_done = done;
        out_data_nxt.status     = ST_TICK_OK;
        replay_nxt              = lvl_next;
        fresh_nxt               = done;
        if (done) begin
          cur_nxt = (idx_inc >= count_r) ? '0 : idx_inc[IDX_W-1:0];
        end else begin
          cur_nxt = tick_idx_r;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      tick_idx_r  <= '0;
      replay_r    <= '0;
      fresh_r     <= 1'b1;
      builder_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      tick_idx_r  <= tick_idx_nxt;
      replay_r    <= replay_nxt;
      fresh_r     <= fresh_nxt;
      builder_r   <= builder_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/pres_level_step.sv
`timescale 1ns / 1ps

// One slew-limited step toward the target; snaps to it when within one step or when the step is zero.
module pres_level_step #(
  parameter int LEVEL_WIDTH = 16
) (
  input  logic [LEVEL_WIDTH-1:0] level,
  input  logic [LEVEL_WIDTH-1:0] target,
  input  logic [LEVEL_WIDTH-1:0] step,
  output logic [LEVEL_WIDTH-1:0] level_next
);

  logic                   above;
  logic [LEVEL_WIDTH-1:0] diff;

  assign above = level > target;
  assign diff  = above ? (level - target) : (target - level);

  always_comb begin
    if ((step == '0) || (diff <= step)) begin
      level_next = target;
    end else if (above) begin
      level_next = level - step;
    end else begin
      level_next = level + step;
    end
  end

endmodule
